// ===== src/cau_pkg.sv =====
package cau_pkg;

	localparam int OpW = 16;
	localparam int ResW = 24;
	localparam int CordicSteps = 21;
	localparam int QueueDepthDefault = 4;

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_EQ  = 3'd4,
		ACT_MAG = 3'd5,
		ACT_ANG = 3'd6,
		ACT_NOP = 3'd7
	} action_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [15:0] a_re;
		logic signed [15:0] a_im;
		logic signed [15:0] b_re;
		logic signed [15:0] b_im;
	} cau_in_t;

	typedef struct packed {
		logic signed [23:0] res_re;
		logic signed [23:0] res_im;
		logic               equal;
		logic               div_zero;
		logic               saturated;
	} cau_out_t;

	// Classified item passed from the front part to the back part.
	typedef struct packed {
		cau_in_t item;
		logic    eq;
		logic    b_zero;
		logic    a_zero;
	} cau_cls_t;

	localparam int ResMax = 8388607;
	localparam int ResMin = -8388608;

	function automatic logic [22:0] atan_q16(input logic [4:0] i);
		logic [22:0] v;
		begin
			case (i)
				5'd0: v = 23'd2949120;
				5'd1: v = 23'd1740967;
				5'd2: v = 23'd919879;
				5'd3: v = 23'd466945;
				5'd4: v = 23'd234379;
				5'd5: v = 23'd117304;
				5'd6: v = 23'd58666;
				5'd7: v = 23'd29335;
				5'd8: v = 23'd14668;
				5'd9: v = 23'd7334;
				5'd10: v = 23'd3667;
				5'd11: v = 23'd1833;
				5'd12: v = 23'd917;
				5'd13: v = 23'd458;
				5'd14: v = 23'd229;
				5'd15: v = 23'd115;
				5'd16: v = 23'd57;
				5'd17: v = 23'd29;
				5'd18: v = 23'd14;
				5'd19: v = 23'd7;
				5'd20: v = 23'd4;
				default: v = 23'd0;
			endcase
			return v;
		end
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		logic signed [23:0] r;
		begin
			if (v > 48'sd8388607) r = 24'sh7FFFFF;
			else if (v < -48'sd8388608) r = 24'sh800000;
			else r = v[23:0];
			return r;
		end
	endfunction

	function automatic logic is_sat(input logic signed [47:0] v);
		return (v > 48'sd8388607) || (v < -48'sd8388608);
	endfunction

endpackage

// ===== src/cau_front.sv =====
module cau_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cau_pkg::cau_in_t operands,
	input  logic             q_full,
	output logic             busy,
	output logic             push,
	output cau_pkg::cau_cls_t cls
);
	import cau_pkg::*;

	assign busy = q_full;
	assign push = start && !q_full;

	always_comb begin
		cls.item   = operands;
		cls.eq     = (operands.a_re == operands.b_re) && (operands.a_im == operands.b_im);
		cls.b_zero = (operands.b_re == '0) && (operands.b_im == '0);
		cls.a_zero = (operands.a_re == '0) && (operands.a_im == '0);
	end

	logic unused_clk;
	assign unused_clk = clk ^ arst_n;
endmodule

// ===== src/cau_queue.sv =====
module cau_queue #(
	parameter int Depth = cau_pkg::QueueDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cau_pkg::cau_cls_t din,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output cau_pkg::cau_cls_t dout
);
	import cau_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	cau_cls_t            mem_q [Depth];
	logic [AW-1:0]       wp_q, rp_q;
	logic [AW:0]         cnt_q;

	assign full      = (cnt_q == (AW+1)'(Depth));
	assign not_empty = (cnt_q != '0);
	assign dout      = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
endmodule

// ===== src/cau_back.sv =====
// Pipelined execution: 41 stages. Products are formed ahead of the first
// stage register. A radix-2 restoring divider advances one step in every
// stage; a bit-pair square root and a CORDIC advance one step per stage
// until their steps are done. Each stage carries all units for its item.
module cau_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  cau_pkg::cau_cls_t cls,
	output logic              done,
	output cau_pkg::cau_out_t result
);
	import cau_pkg::*;

	localparam int NS = 41;
	localparam int QB = 41;  // quotient bits of 2*q+1 numerator / 2den

	typedef struct packed {
		logic [2:0]          act;
		logic                eq;
		logic                bz;
		logic                az;
		logic signed [23:0]  re0;
		logic signed [23:0]  im0;
		logic                sat0;
		// divide
		logic                nr_neg;
		logic                ni_neg;
		logic [49:0]         nr_rem;
		logic [49:0]         ni_rem;
		logic [QB-1:0]       nr_n;
		logic [QB-1:0]       ni_n;
		logic [33:0]         dd;
		// sqrt
		logic [31:0]         s;
		logic [31:0]         r;
		// cordic
		logic signed [40:0]  x;
		logic signed [40:0]  y;
		logic signed [31:0]  z;
		logic                spec_ang;
		logic signed [23:0]  ang_spec;
	} st_t;

	st_t p_s1 [NS];
	logic [NS-1:0] vld_s1;

	// Stage-0 setup.
	st_t s0;
	logic signed [31:0] ar, ai, br, bi;
	logic signed [33:0] pr, pim, den;
	logic signed [41:0] nr, ni;
	logic signed [47:0] mr, mi;
	always_comb begin
		ar = 32'(cls.item.a_re);
		ai = 32'(cls.item.a_im);
		br = 32'(cls.item.b_re);
		bi = 32'(cls.item.b_im);
		s0 = '0;
		s0.act = cls.item.action;
		s0.eq  = cls.eq;
		s0.bz  = cls.b_zero;
		s0.az  = cls.a_zero;
		pr = 34'(ar * br) - 34'(ai * bi);
		pim = 34'(ar * bi) + 34'(ai * br);
		mr = (48'(pr) + 48'sd128) >>> 8;
		mi = (48'(pim) + 48'sd128) >>> 8;
		unique case (action_t'(cls.item.action))
			ACT_ADD: begin s0.re0 = 24'(ar + br); s0.im0 = 24'(ai + bi); end
			ACT_SUB: begin s0.re0 = 24'(ar - br); s0.im0 = 24'(ai - bi); end
			ACT_MUL: begin
				s0.re0 = sat24(mr); s0.im0 = sat24(mi);
				s0.sat0 = is_sat(mr) || is_sat(mi);
			end
			default: ;
		endcase
		// Divide: floor((n*512 + den) / (2 den)).
		den = 34'(br * br) + 34'(bi * bi);
		nr = 42'(34'(ar * br) + 34'(ai * bi)) * 42'sd512 + 42'(den);
		ni = 42'(34'(ai * br) - 34'(ar * bi)) * 42'sd512 + 42'(den);
		s0.nr_neg = nr[41];
		s0.ni_neg = ni[41];
		s0.nr_n = QB'(nr[41] ? -nr : nr);
		s0.ni_n = QB'(ni[41] ? -ni : ni);
		s0.dd = 34'(den) << 1;
		s0.s = 32'(ar * ar + ai * ai);
		// CORDIC with left-half-plane fold.
		s0.spec_ang = (cls.item.a_im == '0) || (cls.item.a_re == '0);
		if (cls.item.a_im == '0)
			s0.ang_spec = (cls.item.a_re < 0) ? 24'sd46080 : 24'sd0;
		else
			s0.ang_spec = (cls.item.a_im > 0) ? 24'sd23040 : -24'sd23040;
		if (cls.item.a_re < 0) begin
			s0.x = -(41'(cls.item.a_re) <<< 20);
			s0.y = -(41'(cls.item.a_im) <<< 20);
			s0.z = (cls.item.a_im > 0) ? 32'sd11796480 : -32'sd11796480;
		end else begin
			s0.x = 41'(cls.item.a_re) <<< 20;
			s0.y = 41'(cls.item.a_im) <<< 20;
		end
	end

	function automatic st_t step(input st_t i, input int k);
		st_t o;
		logic [50:0] t;
		logic [33:0] bitv;
		logic signed [40:0] dx, dy;
		begin
			o = i;
			// Divider: one quotient bit per stage for both parts (MSB first).
			if (k < QB) begin
				t = {i.nr_rem[49:0], i.nr_n[QB-1]};
				o.nr_n = {i.nr_n[QB-2:0], 1'b0};
				if (t >= 51'(i.dd)) begin o.nr_rem = 50'(t - 51'(i.dd)); o.nr_n[0] = 1'b1; end
				else o.nr_rem = 50'(t);
				t = {i.ni_rem[49:0], i.ni_n[QB-1]};
				o.ni_n = {i.ni_n[QB-2:0], 1'b0};
				if (t >= 51'(i.dd)) begin o.ni_rem = 50'(t - 51'(i.dd)); o.ni_n[0] = 1'b1; end
				else o.ni_rem = 50'(t);
			end
			// Square root: one result bit per stage over 16 stages.
			if (k < 16) begin
				bitv = 34'd1 << (2 * (15 - k));
				if (34'(i.s) >= 34'(i.r) + bitv) begin
					o.s = 32'(34'(i.s) - 34'(i.r) - bitv);
					o.r = 32'((34'(i.r) >> 1) + bitv);
				end else o.r = i.r >> 1;
			end
			// CORDIC iteration.
			if (k < CordicSteps) begin
				dx = i.y >>> k;
				dy = i.x >>> k;
				if (i.y >= 0) begin
					o.x = i.x + dx; o.y = i.y - dy; o.z = i.z + 32'(atan_q16(5'(k)));
				end else begin
					o.x = i.x - dx; o.y = i.y + dy; o.z = i.z - 32'(atan_q16(5'(k)));
				end
			end
			return o;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= '0;
		end else begin
			vld_s1 <= {vld_s1[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= step(s0, 0);
		for (int k = 1; k < NS; k++) p_s1[k] <= step(p_s1[k-1], k);
	end

	st_t f;
	logic signed [QB:0] qr, qi;
	logic signed [47:0] qr48, qi48;
	logic [31:0] rt;
	logic signed [31:0] zr;
	always_comb begin
		f = p_s1[NS-1];
		// Floor division for negative numerators: -ceil(|n|/d).
		qr = f.nr_neg ? -((QB+1)'(f.nr_n) + (QB+1)'(f.nr_rem != '0))
		              : (QB+1)'(f.nr_n);
		qi = f.ni_neg ? -((QB+1)'(f.ni_n) + (QB+1)'(f.ni_rem != '0))
		              : (QB+1)'(f.ni_n);
		qr48 = 48'(qr);
		qi48 = 48'(qi);
		rt = (f.s > f.r) ? f.r + 1 : f.r;
		zr = (f.z + 32'sd128) >>> 8;
		result = '0;
		done = vld_s1[NS-1];
		unique case (action_t'(f.act))
			ACT_ADD, ACT_SUB, ACT_MUL: begin
				result.res_re = f.re0; result.res_im = f.im0; result.saturated = f.sat0;
			end
			ACT_DIV: begin
				if (f.bz) result.div_zero = 1'b1;
				else begin
					result.res_re = sat24(qr48);
					result.res_im = sat24(qi48);
					result.saturated = is_sat(qr48) || is_sat(qi48);
				end
			end
			ACT_EQ:  result.equal = f.eq;
			ACT_MAG: result.res_re = 24'(rt);
			ACT_ANG: begin
				if (f.az) result.div_zero = 1'b1;
				else result.res_re = f.spec_ang ? f.ang_spec : 24'(zr);
			end
			default: ;
		endcase
	end
endmodule

// ===== src/complex_arithmetic_unit_core.sv =====
// Complex arithmetic unit. A word is taken whenever start is high and busy
// is low; its result appears on result with done high for one cycle, after
// the queue and the back stages, in order. With a QueueDepth of 2 or more one
// word can be taken every cycle: the back part is a fully pipelined 41-stage
// datapath (restoring divider, square root and CORDIC each retire at most one
// step per stage), so busy rises only if the short front queue fills, which
// then never happens since the back part never stalls.
module complex_arithmetic_unit_core #(
	parameter int QueueDepth = cau_pkg::QueueDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cau_pkg::cau_in_t  operands,
	output logic              busy,
	output logic              done,
	output cau_pkg::cau_out_t result
);
	import cau_pkg::*;

	logic     push, q_full, q_ne;
	cau_cls_t cls_f, cls_b;

	cau_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .operands(operands),
		.q_full(q_full), .busy(busy), .push(push), .cls(cls_f)
	);

	cau_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(cls_f), .pop(q_ne),
		.full(q_full), .not_empty(q_ne), .dout(cls_b)
	);

	cau_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_ne), .cls(cls_b),
		.done(done), .result(result)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push) else $error("push into full queue");
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy == q_full) else $error("busy mismatch");
	a_eq_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.equal |-> result.res_re == '0 && result.res_im == '0)
		else $error("equal with nonzero result");
`endif
endmodule

// ===== test/tb_complex_arithmetic_unit_core.sv =====
module tb_complex_arithmetic_unit_core;
	import cau_pkg::*;

	localparam int Latency = 41;
	localparam int CycleLimit = 200000;
	localparam int RandomWords = 600;

	typedef struct {
		cau_in_t  w;
		bit       typed;
		cau_out_t r;
	} vec_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	cau_in_t  operands = '0;
	logic     busy;
	logic     done;
	cau_out_t result;

	// Side information for the word on the operand bus.
	bit       cur_typed = 1'b0;
	cau_out_t cur_result = '0;

	cau_out_t pending_results[$];
	int       words_taken = 0;
	int       errors = 0;
	int       cycles = 0;
	vec_t     directed_vecs[$];

	complex_arithmetic_unit_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operands (operands),
		.busy     (busy),
		.done     (done),
		.result   (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clip24(input longint v);
		if (v > ResMax) return ResMax;
		if (v < ResMin) return ResMin;
		return v;
	endfunction

	function automatic bit out_of_range(input longint v);
		return (v > ResMax) || (v < ResMin);
	endfunction

	function automatic longint floor_div(input longint n, input longint d);
		if (n >= 0) return n / d;
		return -((-n + d - 1) / d);
	endfunction

	function automatic longint nearest_sqrt(input longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 32;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (s > r) r = r + 1;
		return longint'(r);
	endfunction

	// Four-quadrant angle in Q16.8 degrees; the left half-plane is turned
	// by 180 degrees before the vectoring iterations.
	function automatic longint angle_deg(input longint ar, input longint ai);
		longint x, y, z, dx, dy;
		z = 0;
		if (ai == 0) return (ar < 0) ? 180 * 256 : 0;
		if (ar == 0) return (ai > 0) ? 180 * 128 : -180 * 128;
		x = ar * 1048576;
		y = ai * 1048576;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = (ai > 0) ? 180 * 65536 : -180 * 65536;
		end
		for (int i = 0; i < CordicSteps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(atan_q16(5'(i)));
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(atan_q16(5'(i)));
			end
		end
		return (z + 128) >>> 8;
	endfunction

	function automatic cau_out_t cau_predict(input cau_in_t w);
		longint ar, ai, br, bi, re, im, den, nr, ni;
		cau_out_t r;
		ar = w.a_re;
		ai = w.a_im;
		br = w.b_re;
		bi = w.b_im;
		re = 0;
		im = 0;
		r = '0;
		case (action_t'(w.action))
			ACT_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			ACT_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			ACT_MUL: begin
				re = (ar * br - ai * bi + 128) >>> 8;
				im = (ar * bi + ai * br + 128) >>> 8;
				r.saturated = out_of_range(re) || out_of_range(im);
			end
			ACT_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.div_zero = 1'b1;
				end else begin
					nr = (ar * br + ai * bi) * 512;
					ni = (ai * br - ar * bi) * 512;
					re = floor_div(nr + den, 2 * den);
					im = floor_div(ni + den, 2 * den);
					r.saturated = out_of_range(re) || out_of_range(im);
				end
			end
			ACT_EQ: r.equal = (ar == br) && (ai == bi);
			ACT_MAG: re = nearest_sqrt(longint'(ar * ar + ai * ai));
			ACT_ANG: begin
				if (ar == 0 && ai == 0) r.div_zero = 1'b1;
				else re = angle_deg(ar, ai);
			end
			default: ;
		endcase
		r.res_re = 24'(clip24(re));
		r.res_im = 24'(clip24(im));
		return r;
	endfunction

	function automatic vec_t row(input action_t a, input int ar, input int ai,
		input int br, input int bi, input bit typed, input int re = 0,
		input int im = 0, input bit eq = 0, input bit dz = 0, input bit sat = 0);
		vec_t v;
		v.w = '{action: a, a_re: 16'(ar), a_im: 16'(ai), b_re: 16'(br), b_im: 16'(bi)};
		v.typed = typed;
		v.r = '{res_re: 24'(re), res_im: 24'(im), equal: eq, div_zero: dz,
			saturated: sat};
		return v;
	endfunction

	task automatic report_mismatch(input string field, input longint got,
		input longint want);
		$display("mismatch on word %0d: %s got %0d, expected %0d",
			words_taken - pending_results.size(), field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Accepted words are predicted and results checked at the rising edge.
	always @(posedge clk) begin
		cau_out_t want;
		if (arst_n && start && !busy) begin
			pending_results.push_back(cur_typed ? cur_result : cau_predict(operands));
			words_taken++;
		end
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("unexpected result word");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.res_re !== want.res_re)
					report_mismatch("res_re", result.res_re, want.res_re);
				if (result.res_im !== want.res_im)
					report_mismatch("res_im", result.res_im, want.res_im);
				if (result.equal !== want.equal)
					report_mismatch("equal", result.equal, want.equal);
				if (result.div_zero !== want.div_zero)
					report_mismatch("div_zero", result.div_zero, want.div_zero);
				if (result.saturated !== want.saturated)
					report_mismatch("saturated", result.saturated, want.saturated);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input cau_in_t w, input bit typed, input cau_out_t r);
		int n;
		n = words_taken;
		start <= 1'b1;
		operands <= w;
		cur_typed <= typed;
		cur_result <= r;
		do @(negedge clk); while (words_taken == n);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic int rand_operand(input bit narrow);
		if (narrow) return $urandom_range(0, 1023) - 512;
		return int'($signed(16'($urandom)));
	endfunction

	initial begin
		cau_in_t w;
		int style;
		bit narrow;

		directed_vecs.push_back(row(ACT_ADD, 32767, -32768, 32767, -32768, 1, 65534, -65536));
		directed_vecs.push_back(row(ACT_SUB, -32768, 32767, 32767, -32768, 1, -65535, 65535));
		directed_vecs.push_back(row(ACT_MUL, -32768, -32768, -32768, -32768, 1, 0, 8388607,
			0, 0, 1));
		directed_vecs.push_back(row(ACT_MUL, 256, 0, 0, 256, 1, 0, 256));
		directed_vecs.push_back(row(ACT_MUL, 32767, 32767, 32767, -32768, 0));
		directed_vecs.push_back(row(ACT_DIV, 1000, -5, 0, 0, 1, 0, 0, 0, 1));
		directed_vecs.push_back(row(ACT_DIV, -32768, 0, 1, 0, 1, -8388608, 0));
		directed_vecs.push_back(row(ACT_DIV, 512, 0, 256, 0, 1, 512, 0));
		directed_vecs.push_back(row(ACT_DIV, 32767, -32768, 1, 1, 0));
		directed_vecs.push_back(row(ACT_DIV, -32768, -32768, 32767, -32768, 0));
		directed_vecs.push_back(row(ACT_EQ, 123, -45, 123, -45, 1, 0, 0, 1));
		directed_vecs.push_back(row(ACT_EQ, 123, -45, 123, -44, 1));
		directed_vecs.push_back(row(ACT_EQ, -32768, 32767, -32768, 32767, 1, 0, 0, 1));
		directed_vecs.push_back(row(ACT_MAG, -32768, -32768, 0, 0, 1, 46341));
		directed_vecs.push_back(row(ACT_MAG, 768, 1024, 5, 5, 1, 1280));
		directed_vecs.push_back(row(ACT_MAG, 0, 0, 0, 0, 1));
		directed_vecs.push_back(row(ACT_ANG, 0, 0, 7, 7, 1, 0, 0, 0, 1));
		directed_vecs.push_back(row(ACT_ANG, 256, 0, 0, 0, 1));
		directed_vecs.push_back(row(ACT_ANG, -256, 0, 0, 0, 1, 46080));
		directed_vecs.push_back(row(ACT_ANG, 0, 256, 0, 0, 1, 23040));
		directed_vecs.push_back(row(ACT_ANG, 0, -1, 0, 0, 1, -23040));
		directed_vecs.push_back(row(ACT_ANG, -32768, -1, 0, 0, 0));
		directed_vecs.push_back(row(ACT_ANG, -1, 32767, 0, 0, 0));
		directed_vecs.push_back(row(ACT_ANG, 100, 100, 0, 0, 0));
		directed_vecs.push_back(row(ACT_NOP, 32767, -32768, 32767, -32768, 1));

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_vecs[i])
			send_word(directed_vecs[i].w, directed_vecs[i].typed, directed_vecs[i].r);

		for (int i = 0; i < RandomWords; i++) begin
			// No idling over a long middle stretch.
			if ((i < 200 || i >= 350) && $urandom_range(0, 99) < 3)
				idle_cycles($urandom_range(1, 3));
			if (i == 400) begin
				start <= 1'b0;
				while (pending_results.size() != 0) @(negedge clk);
			end
			style = $urandom_range(0, 9);
			narrow = (style >= 4 && style <= 6);
			w.action = 3'($urandom_range(0, 7));
			w.a_re = 16'(rand_operand(narrow));
			w.a_im = 16'(rand_operand(narrow));
			w.b_re = 16'(rand_operand(narrow));
			w.b_im = 16'(rand_operand(narrow));
			if (style == 7) begin
				w.b_re = w.a_re;
				w.b_im = w.a_im;
			end else if (style == 8) begin
				w.b_re = '0;
				w.b_im = '0;
			end else if (style == 9) begin
				if ($urandom_range(0, 1)) w.a_re = '0;
				else w.a_im = '0;
			end
			send_word(w, 1'b0, '0);
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (Latency + 4) @(negedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== complex_arithmetic_unit_core.f =====
src/cau_pkg.sv
src/cau_front.sv
src/cau_queue.sv
src/cau_back.sv
src/complex_arithmetic_unit_core.sv
test/tb_complex_arithmetic_unit_core.sv
